>>> rtl/tcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

   // Screen geometry.
   localparam int COLUMNS   = 80;
   localparam int ROWS      = 25;
   localparam int TAB_WIDTH = 8;

   localparam int CELLS        = ROWS * COLUMNS;
   localparam int SCROLL_CELLS = (ROWS - 1) * COLUMNS;

   // Field widths of the transactions.
   localparam int ACT_W  = 2;
   localparam int CHAR_W = 8;
   localparam int COLR_W = 4;
   localparam int COL_W  = 7;
   localparam int ROW_W  = 5;
   localparam int LOC_W  = 11;
   localparam int CELL_W = 16;

   // Cell buffer addressing; the sweep counter is sized to hold CELLS itself.
   localparam int ADDR_W = $clog2(CELLS);
   localparam int IDX_W  = $clog2(CELLS + 1);

   localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

   // Action codes.
   localparam logic [ACT_W-1:0] ACT_PUT   = 2'd0;
   localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd1;
   localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

   // Character codes with special handling.
   localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_LAST  = 8'h7F;

   // Cursor update computed for one put transaction.
   typedef struct packed {
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic [LOC_W-1:0] loc;
      logic             printable;
      logic             scroll;
   } cursor_upd_type;

endpackage

`default_nettype wire

>>> rtl/tcw_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tcw_req_if;
   logic                       valid;
   logic                       ready;
   logic [tcw_pkg::ACT_W-1:0]  action;
   logic [tcw_pkg::CHAR_W-1:0] char_code;
   logic [tcw_pkg::COLR_W-1:0] bg_color;
   logic [tcw_pkg::COLR_W-1:0] fg_color;
   logic [tcw_pkg::LOC_W-1:0]  cell_index;

   modport source (output valid, action, char_code, bg_color, fg_color, cell_index,
                   input ready);
   modport sink (input valid, action, char_code, bg_color, fg_color, cell_index,
                 output ready);
endinterface

`default_nettype wire

>>> rtl/tcw_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tcw_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [tcw_pkg::COL_W-1:0]  cursor_col;
   logic [tcw_pkg::ROW_W-1:0]  cursor_row;
   logic [tcw_pkg::LOC_W-1:0]  cursor_location;
   logic [tcw_pkg::CELL_W-1:0] cell_data;

   modport source (output valid, cursor_col, cursor_row, cursor_location, cell_data,
                   input ready);
   modport sink (input valid, cursor_col, cursor_row, cursor_location, cell_data,
                 output ready);
endinterface

`default_nettype wire

>>> rtl/tcw_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

>>> rtl/tcw_cursor.sv
`timescale 1ns / 1ps
`default_nettype none

module tcw_cursor (
   input  wire logic [tcw_pkg::CHAR_W-1:0] char_code,
   input  wire logic [tcw_pkg::COL_W-1:0]  col,
   input  wire logic [tcw_pkg::ROW_W-1:0]  row,
   output tcw_pkg::cursor_upd_type         upd
);

   logic [tcw_pkg::COL_W:0] col_x;
   logic [tcw_pkg::ROW_W:0] row_x;
   logic                    printable;
   logic                    scroll;

   // Move the cursor for one character, then wrap and scroll.
   always_comb begin
      col_x     = {1'b0, col};
      row_x     = {1'b0, row};
      printable = 1'b0;
      scroll    = 1'b0;

      if (char_code == tcw_pkg::CH_BS && col != '0) begin
         col_x = col_x - 1'b1;
      end else if (char_code == tcw_pkg::CH_TAB) begin
         // Tab width is a power of two, so the remainder is a mask.
         col_x = (col_x & ~((tcw_pkg::COL_W + 1)'(tcw_pkg::TAB_WIDTH - 1)))
                 + (tcw_pkg::COL_W + 1)'(tcw_pkg::TAB_WIDTH);
      end else if (char_code == tcw_pkg::CH_CR) begin
         col_x = '0;
      end else if (char_code == tcw_pkg::CH_LF) begin
         col_x = '0;
         row_x = row_x + 1'b1;
      end else if (char_code >= tcw_pkg::CH_SPACE && char_code <= tcw_pkg::CH_LAST) begin
         printable = 1'b1;
         col_x     = col_x + 1'b1;
      end

      if (col_x >= (tcw_pkg::COL_W + 1)'(tcw_pkg::COLUMNS)) begin
         col_x = '0;
         row_x = row_x + 1'b1;
      end

      if (row_x >= (tcw_pkg::ROW_W + 1)'(tcw_pkg::ROWS)) begin
         row_x  = (tcw_pkg::ROW_W + 1)'(tcw_pkg::ROWS - 1);
         scroll = 1'b1;
      end
   end

   // Pack the result, with the linear cursor location.
   always_comb begin
      upd.col       = col_x[tcw_pkg::COL_W-1:0];
      upd.row       = row_x[tcw_pkg::ROW_W-1:0];
      upd.loc       = tcw_pkg::LOC_W'(row_x[tcw_pkg::ROW_W-1:0])
                      * tcw_pkg::LOC_W'(tcw_pkg::COLUMNS)
                      + tcw_pkg::LOC_W'(col_x[tcw_pkg::COL_W-1:0]);
      upd.printable = printable;
      upd.scroll    = scroll;
   end

endmodule

`default_nettype wire

>>> rtl/text_console_writer.sv
// A plain put or other action registers its result on acceptance; a read goes through
// ST_READ; a clear blanks every cell; a put that scrolls copies rows, then blanks the last row.
// One transaction at a time: the next request is taken only once the result register
// has been emptied by the receiver.
// The cell buffer has one read and one write port; sweeps touch one cell per cycle.
// Reset: a clearing pass blanks the buffer, not ready meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer (
   input wire logic  clock,
   input wire logic  reset,
   tcw_req_if.sink   req,
   tcw_rsp_if.source rsp
);

   typedef enum logic [4:0] {
      ST_INIT   = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_READ   = 5'b00100,
      ST_SCROLL = 5'b01000,
      ST_BLANK  = 5'b10000
   } state_type;

   state_type                   state_ff, state_in;
   logic [tcw_pkg::IDX_W-1:0]   idx_ff, idx_in;
   logic                        pend_ff, pend_in;
   logic [tcw_pkg::ADDR_W-1:0]  waddr_ff, waddr_in;
   logic [tcw_pkg::COL_W-1:0]   cur_col_ff, cur_col_in;
   logic [tcw_pkg::ROW_W-1:0]   cur_row_ff, cur_row_in;
   logic [tcw_pkg::LOC_W-1:0]   cur_loc_ff, cur_loc_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [tcw_pkg::CELL_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                        in_range_ff, in_range_in;

   logic                        req_fire;
   logic                        ram_we;
   logic [tcw_pkg::ADDR_W-1:0]  ram_waddr;
   logic [tcw_pkg::CELL_W-1:0]  ram_wdata;
   logic [tcw_pkg::ADDR_W-1:0]  ram_raddr;
   logic [tcw_pkg::CELL_W-1:0]  ram_rdata;
   tcw_pkg::cursor_upd_type     upd;

   tcw_ram #(
      .WIDTH (tcw_pkg::CELL_W),
      .DEPTH (tcw_pkg::CELLS)
   ) u_buffer (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   tcw_cursor u_cursor (
      .char_code (req.char_code),
      .col       (cur_col_ff),
      .row       (cur_row_ff),
      .upd       (upd)
   );

   // Handshake: one transaction at a time, taken once the result has left.
   assign req.ready           = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign req_fire            = req.valid && req.ready;
   assign rsp.valid           = rsp_valid_ff;
   assign rsp.cursor_col      = cur_col_ff;
   assign rsp.cursor_row      = cur_row_ff;
   assign rsp.cursor_location = cur_loc_ff;
   assign rsp.cell_data       = rsp_data_ff;

   // Sequencer: reset clearing pass, single actions, the row copy sweep and the blanking sweep.
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      pend_in      = 1'b0;
      waddr_in     = waddr_ff;
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      cur_loc_in   = cur_loc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_data_in  = rsp_data_ff;
      in_range_in  = in_range_ff;
      ram_we       = 1'b0;
      ram_waddr    = '0;
      ram_wdata    = '0;
      ram_raddr    = '0;

      case (state_ff)
         ST_INIT: begin
            ram_we    = 1'b1;
            ram_waddr = idx_ff[tcw_pkg::ADDR_W-1:0];
            ram_wdata = tcw_pkg::BLANK_CELL;
            if (idx_ff == tcw_pkg::IDX_W'(tcw_pkg::CELLS - 1)) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               rsp_data_in = '0;
               case (req.action)
                  tcw_pkg::ACT_PUT: begin
                     cur_col_in = upd.col;
                     cur_row_in = upd.row;
                     cur_loc_in = upd.loc;
                     if (upd.printable) begin
                        ram_we    = 1'b1;
                        ram_waddr = tcw_pkg::ADDR_W'(cur_loc_ff);
                        ram_wdata = {req.bg_color, req.fg_color, req.char_code};
                     end
                     if (upd.scroll) begin
                        idx_in   = '0;
                        state_in = ST_SCROLL;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  tcw_pkg::ACT_CLEAR: begin
                     cur_col_in = '0;
                     cur_row_in = '0;
                     cur_loc_in = '0;
                     idx_in     = '0;
                     state_in   = ST_BLANK;
                  end
                  tcw_pkg::ACT_READ: begin
                     ram_raddr   = tcw_pkg::ADDR_W'(req.cell_index);
                     in_range_in = req.cell_index < tcw_pkg::LOC_W'(tcw_pkg::CELLS);
                     state_in    = ST_READ;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_data_in  = in_range_ff ? ram_rdata : '0;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_SCROLL: begin
            // Read one row ahead, write the word read in the cycle before.
            if (pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = waddr_ff;
               ram_wdata = ram_rdata;
            end
            if (idx_ff < tcw_pkg::IDX_W'(tcw_pkg::SCROLL_CELLS)) begin
               ram_raddr = tcw_pkg::ADDR_W'(idx_ff + tcw_pkg::IDX_W'(tcw_pkg::COLUMNS));
               pend_in   = 1'b1;
               waddr_in  = idx_ff[tcw_pkg::ADDR_W-1:0];
               idx_in    = idx_ff + 1'b1;
            end else begin
               state_in = ST_BLANK;
            end
         end
         ST_BLANK: begin
            ram_we    = 1'b1;
            ram_waddr = idx_ff[tcw_pkg::ADDR_W-1:0];
            ram_wdata = tcw_pkg::BLANK_CELL;
            if (idx_ff == tcw_pkg::IDX_W'(tcw_pkg::CELLS - 1)) begin
               idx_in       = '0;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and cursor registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         cur_loc_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         cur_loc_ff   <= cur_loc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      waddr_ff    <= waddr_in;
      rsp_data_ff <= rsp_data_in;
      in_range_ff <= in_range_in;
   end

   // The cursor always stays on the screen.
   assert property (@(posedge clock) disable iff (reset)
      cur_col_ff < tcw_pkg::COL_W'(tcw_pkg::COLUMNS)
      && cur_row_ff < tcw_pkg::ROW_W'(tcw_pkg::ROWS))
      else $error("cursor left the screen");

   // The reported location matches the column and row.
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.cursor_location ==
         tcw_pkg::LOC_W'(cur_row_ff) * tcw_pkg::LOC_W'(tcw_pkg::COLUMNS)
         + tcw_pkg::LOC_W'(cur_col_ff))
      else $error("cursor location out of step with column and row");

   // A new request is never taken while a result is pending.
   assert property (@(posedge clock) disable iff (reset)
      req_fire |-> !rsp_valid_ff && state_ff == ST_IDLE)
      else $error("request taken while busy");

   // Buffer writes stay inside the screen.
   assert property (@(posedge clock) disable iff (reset)
      ram_we |-> ram_waddr < tcw_pkg::ADDR_W'(tcw_pkg::CELLS))
      else $error("buffer write out of range");

   // A result follows a plain put in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_fire && req.action == tcw_pkg::ACT_PUT && !upd.scroll |=> rsp_valid_ff)
      else $error("put transaction produced no result");

endmodule

`default_nettype wire

>>> tb/sv/tcw_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the console writer, keeps its own copy of the
// cell buffer and cursor, and compares every reply transaction in order.
module tcw_checker
   import tcw_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   tcw_req_if       req,
   tcw_rsp_if       rsp,
   output int       fail_count,
   output int       replies_owed
);

   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
      logic [LOC_W-1:0]  loc;
      logic [CELL_W-1:0] data;
   } console_reply_type;

   logic [CELL_W-1:0] screen [CELLS];
   logic [COL_W-1:0]  cur_x;
   logic [ROW_W-1:0]  cur_y;
   console_reply_type console_replies [$];
   int                failures = 0;
   int                reports = 0;

   function automatic void blank_screen();
      for (int i = 0; i < CELLS; i++) begin
         screen[i] = BLANK_CELL;
      end
   endfunction

   // One byte of a put transaction: control codes move the cursor, printable
   // bytes are stored, everything else leaves the cursor alone.
   function automatic void put_byte(logic [CHAR_W-1:0] ch, logic [COLR_W-1:0] bk,
                                    logic [COLR_W-1:0] fr);
      int x;
      int y;
      x = cur_x;
      y = cur_y;
      if (ch == CH_BS && x != 0) begin
         x = x - 1;
      end else if (ch == CH_TAB) begin
         x = x + TAB_WIDTH - (x % TAB_WIDTH);
      end else if (ch == CH_CR) begin
         x = 0;
      end else if (ch == CH_LF) begin
         x = 0;
         y = y + 1;
      end else if (ch >= CH_SPACE && ch <= CH_LAST) begin
         screen[y * COLUMNS + x] = {bk, fr, ch};
         x = x + 1;
      end

      // Wrap at the right edge.
      if (x >= COLUMNS) begin
         x = 0;
         y = y + 1;
      end

      // Past the last row the whole screen moves up by one row.
      if (y >= ROWS) begin
         for (int i = 0; i < SCROLL_CELLS; i++) begin
            screen[i] = screen[i + COLUMNS];
         end
         for (int i = SCROLL_CELLS; i < CELLS; i++) begin
            screen[i] = BLANK_CELL;
         end
         y = ROWS - 1;
      end
      cur_x = COL_W'(x);
      cur_y = ROW_W'(y);
   endfunction

   // Applies one request transaction and returns the reply it must produce.
   function automatic console_reply_type apply_action(logic [ACT_W-1:0] act,
                                                      logic [CHAR_W-1:0] ch,
                                                      logic [COLR_W-1:0] bk,
                                                      logic [COLR_W-1:0] fr,
                                                      logic [LOC_W-1:0] idx);
      console_reply_type reply;
      reply.data = '0;
      case (act)
         ACT_PUT: begin
            put_byte(ch, bk, fr);
         end
         ACT_CLEAR: begin
            blank_screen();
            cur_x = '0;
            cur_y = '0;
         end
         ACT_READ: begin
            if (idx < CELLS) begin
               reply.data = screen[idx];
            end
         end
         default: begin
         end
      endcase
      reply.col = cur_x;
      reply.row = cur_y;
      reply.loc = LOC_W'(cur_y * COLUMNS + cur_x);
      return reply;
   endfunction

   // Replies are checked before the request of the same edge is applied,
   // since no reply can belong to a request accepted at that edge.
   always @(posedge clock) begin : watch
      console_reply_type want;
      console_reply_type got;
      if (reset) begin
         blank_screen();
         cur_x = '0;
         cur_y = '0;
         console_replies.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.cursor_col, rsp.cursor_row, rsp.cursor_location, rsp.cell_data};
            if (console_replies.size() == 0) begin
               failures++;
               if (reports < MAX_REPORTS) begin
                  reports++;
                  $display("unexpected reply: col %0d row %0d loc %0d data %h",
                           got.col, got.row, got.loc, got.data);
               end
            end else begin
               want = console_replies.pop_front();
               if (got !== want) begin
                  failures++;
                  if (reports < MAX_REPORTS) begin
                     reports++;
                     $display("wrong reply: expected col %0d row %0d loc %0d data %h",
                              want.col, want.row, want.loc, want.data);
                     $display("             actual   col %0d row %0d loc %0d data %h",
                              got.col, got.row, got.loc, got.data);
                  end
               end
            end
         end
         if (req.valid && req.ready) begin
            console_replies.push_back(apply_action(req.action, req.char_code,
                                                   req.bg_color, req.fg_color,
                                                   req.cell_index));
         end
      end
      fail_count   <= failures;
      replies_owed <= console_replies.size();
   end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import tcw_pkg::*;

   // Action code that the block accepts but does nothing with.
   localparam logic [ACT_W-1:0] ACT_NOP = 2'd3;

   localparam int RANDOM_ITEMS = 1400;
   localparam int STALL_LIMIT  = 20000;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 20;

   logic clock;
   logic reset;
   int   fail_count;
   int   replies_owed;
   int   items_sent = 0;
   int   idle_cycles = 0;
   int   send_burst = 0;

   tcw_req_if req ();
   tcw_rsp_if rsp ();

   text_console_writer u_top (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   tcw_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req          (req),
      .rsp          (rsp),
      .fail_count   (fail_count),
      .replies_owed (replies_owed)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 16);
      return $urandom_range(40, 150);
   endfunction

   // Offers one request transaction, waits for it to be taken, then idles for a random gap, if any.
   task automatic send_item(input logic [ACT_W-1:0] act, input logic [CHAR_W-1:0] ch,
                            input logic [COLR_W-1:0] bk, input logic [COLR_W-1:0] fr,
                            input logic [LOC_W-1:0] idx);
      int gap;
      @(negedge clock);
      req.valid      = 1'b1;
      req.action     = act;
      req.char_code  = ch;
      req.bg_color   = bk;
      req.fg_color   = fr;
      req.cell_index = idx;
      do @(posedge clock); while (!req.ready);
      items_sent++;
      if (send_burst > 0) begin
         send_burst--;
         gap = 0;
      end else begin
         gap = pick_gap();
         if ($urandom_range(0, 99) < 3) send_burst = $urandom_range(20, 60);
      end
      if (gap > 0) begin
         @(negedge clock);
         req.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Character mix: mostly text, with control codes and ignored bytes.
   function automatic logic [CHAR_W-1:0] pick_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 62) return CHAR_W'($urandom_range(CH_SPACE, CH_LAST));
      if (r < 72) return CH_LF;
      if (r < 76) return CH_CR;
      if (r < 82) return CH_BS;
      if (r < 88) return CH_TAB;
      if (r < 93) return CHAR_W'($urandom_range(0, CH_SPACE - 1));
      return CHAR_W'($urandom_range(8'h80, 8'hFF));
   endfunction

   // Read addresses lean toward the bottom rows, where scrolling shows up.
   function automatic logic [LOC_W-1:0] pick_index();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return LOC_W'($urandom_range(0, CELLS - 1));
      if (r < 92) return LOC_W'($urandom_range(SCROLL_CELLS, CELLS - 1));
      return LOC_W'($urandom_range(CELLS, (1 << LOC_W) - 1));
   endfunction

   task automatic send_random();
      int                r;
      logic [ACT_W-1:0]  act;
      r = $urandom_range(0, 99);
      if (r < 3) begin
         act = ACT_CLEAR;
      end else if (r < 5) begin
         act = ACT_NOP;
      end else if (r < 20) begin
         act = ACT_READ;
      end else begin
         act = ACT_PUT;
      end
      send_item(act, (act == ACT_PUT) ? pick_char() : CHAR_W'($urandom_range(0, 255)),
                COLR_W'($urandom_range(0, 15)), COLR_W'($urandom_range(0, 15)),
                (act == ACT_READ) ? pick_index() : LOC_W'($urandom_range(0, 2047)));
   endtask

   // Receiver: random ready pattern, plus two long hold-offs that let the
   // block back up and stall the request side.
   initial begin : receiver
      int holds_done;
      int run;
      int gap;
      holds_done = 0;
      rsp.ready  = 1'b0;
      forever begin
         if (holds_done < 2 && items_sent >= ((holds_done == 0) ? 30 : 700)) begin
            @(negedge clock);
            rsp.ready = 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            holds_done++;
         end else begin
            run = ($urandom_range(0, 99) < 5) ? $urandom_range(30, 100) :
                                                $urandom_range(1, 12);
            @(negedge clock);
            rsp.ready = 1'b1;
            repeat (run - 1) @(negedge clock);
            gap = pick_gap();
            if (gap > 0) begin
               @(negedge clock);
               rsp.ready = 1'b0;
               repeat (gap - 1) @(negedge clock);
            end
         end
      end
   end

   // Ends the run if no transaction moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("text_console_writer: mismatch");
         $finish;
      end
   end

   initial begin : stimulus
      reset          = 1'b1;
      req.valid      = 1'b0;
      req.action     = ACT_PUT;
      req.char_code  = '0;
      req.bg_color   = '0;
      req.fg_color   = '0;
      req.cell_index = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: blank screen after reset, address extremes, byte
      // classes, backspace at the left edge, tab wrap, CR, LF and clear.
      send_item(ACT_READ, 8'h00, 4'h0, 4'h0, LOC_W'(0));
      send_item(ACT_READ, 8'hFF, 4'hF, 4'hF, LOC_W'(CELLS - 1));
      send_item(ACT_READ, 8'h00, 4'h0, 4'h0, LOC_W'(CELLS));
      send_item(ACT_READ, 8'h00, 4'h0, 4'h0, 11'h7FF);
      send_item(ACT_PUT, CH_BS, 4'h0, 4'h0, LOC_W'(0));
      send_item(ACT_PUT, CH_SPACE, 4'h0, 4'h0, LOC_W'(0));
      send_item(ACT_PUT, 8'h41, 4'hF, 4'hF, 11'h7FF);
      send_item(ACT_PUT, CH_LAST, 4'hA, 4'h5, LOC_W'(0));
      send_item(ACT_PUT, 8'h80, 4'h3, 4'hC, LOC_W'(0));
      send_item(ACT_PUT, 8'hFF, 4'h3, 4'hC, LOC_W'(0));
      send_item(ACT_PUT, 8'h00, 4'h3, 4'hC, LOC_W'(0));
      send_item(ACT_PUT, 8'h1F, 4'h3, 4'hC, LOC_W'(0));
      send_item(ACT_PUT, CH_BS, 4'h0, 4'h0, LOC_W'(0));
      send_item(ACT_READ, 8'h00, 4'h0, 4'h0, LOC_W'(1));
      send_item(ACT_READ, 8'h00, 4'h0, 4'h0, LOC_W'(2));
      // Ten tabs from column two walk across the row and wrap.
      repeat (10) send_item(ACT_PUT, CH_TAB, 4'h0, 4'h0, LOC_W'(0));
      send_item(ACT_PUT, 8'h7A, 4'h1, 4'h2, LOC_W'(0));
      send_item(ACT_PUT, CH_CR, 4'h0, 4'h0, LOC_W'(0));
      send_item(ACT_PUT, CH_LF, 4'h0, 4'h0, LOC_W'(0));
      send_item(ACT_NOP, 8'h41, 4'hF, 4'hF, LOC_W'(5));
      send_item(ACT_CLEAR, 8'h00, 4'h0, 4'h0, LOC_W'(0));
      send_item(ACT_READ, 8'h00, 4'h0, 4'h0, LOC_W'(1));

      // Random part.
      repeat (RANDOM_ITEMS) send_random();

      @(negedge clock);
      req.valid = 1'b0;
      while (replies_owed != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && replies_owed == 0) begin
         $display("text_console_writer: match");
      end else begin
         $display("text_console_writer: mismatch");
      end
      $finish;
   end

endmodule
